/* hw/rtl/prs_pkg.sv */
// Package for the power-rail sequencer: phase encoding, enable bit positions,
// register indexes and field widths.
// No dependencies.
`default_nettype none

package prs_pkg;

    // Field and register widths
    localparam int unsigned DelayWidth = 8;
    localparam int unsigned TpsWidth   = 16;
    localparam int unsigned CountWidth = DelayWidth + TpsWidth;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned EnWidth    = 6;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_ON_FINAL_DELAY  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_OFF_FINAL_DELAY = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_TICKS_PER_SEC   = 2'd2;

    localparam logic [TpsWidth-1:0] TPS_RESET = 16'd1000;

    // Enable bit positions
    localparam int unsigned EN_MOTION = 0;
    localparam int unsigned EN_AC     = 1;
    localparam int unsigned EN_MAIN   = 2;
    localparam int unsigned EN_HEATER = 3;
    localparam int unsigned EN_VPP    = 4;
    localparam int unsigned EN_I2C    = 5;

    // Sequencer phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_STEP1  = 8'b0000_0010,
        PH_WAIT1  = 8'b0000_0100,
        PH_STEP2  = 8'b0000_1000,
        PH_WAIT2  = 8'b0001_0000,
        PH_STEP3  = 8'b0010_0000,
        PH_FINAL  = 8'b0100_0000,
        PH_NOTIFY = 8'b1000_0000
    } phase_t;

    // One result item as packed into m_tdata, lowest bit last
    typedef struct packed {
        logic                notify_level;
        logic                notify_send;
        logic                power_status;
        logic [EnWidth-1:0]  enables;
        logic                busy_res;
        logic                request_accepted;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/power_rail_sequencer.sv */
// Power-rail sequencer: top level with phase sequencer, countdown and
// result register. Depends on prs_pkg.
`default_nettype none

// Usage
// The input channel (s_) carries one item per tick event or power request:
// s_tuser = 1 marks a power request whose level is s_tdata[0]; s_tuser = 0
// marks a tick, and s_tdata[1] then says the link takes a pending notification.
// Each item yields exactly one result item on the m_ channel, showing the
// request verdict, busy flag, the six enables, power status and notification.
// The result of an item accepted at one edge is registered and valid from
// that edge on. Throughput is one item per cycle unless the receiver stalls;
// the single 8x16 multiplier that turns seconds into tick counts sits in
// the same cycle as the phase update.
// When the receiver stalls, the result register holds its item and s_tready
// stays low until m_tready rises, so no result is lost or duplicated.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the
// next edge; indexes beyond the register list are ignored.
// Reset (aresetn low, synchronous) returns to idle with all enables off,
// status 0, both delays 0 and 1000 ticks per second, and empties the result
// register.

module power_rail_sequencer
    import prs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]    cfg_index,
    input  wire logic [TpsWidth-1:0]   cfg_wdata,

    // Input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,  // [0] on_off, [1] notify_ready
    input  wire logic                  s_tuser,  // req_type

    // Result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] request_accepted, [1] busy_res, [2] motion_enable, [3] ac_enable,
    // [4] main24_enable, [5] heater24_enable, [6] vpp_enable, [7] i2c_enable,
    // [8] power_status, [9] notify_send, [10] notify_level
    output logic [15:0]                m_tdata
);

    // Configuration registers
    logic [DelayWidth-1:0] on_delay_reg;
    logic [DelayWidth-1:0] off_delay_reg;
    logic [TpsWidth-1:0]   tps_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  target_reg, target_next;
    logic                  status_reg, status_next;
    logic [EnWidth-1:0]    en_reg, en_next;

    // Result register
    logic                  m_valid_reg;
    result_t               res_reg, res_next;

    logic                  s_accept;
    logic                  req_type;
    logic                  on_off;
    logic                  notify_ready;
    logic [DelayWidth-1:0] secs_sel;
    logic [CountWidth-1:0] load_ticks;

    assign req_type     = s_tuser;
    assign on_off       = s_tdata[0];
    assign notify_ready = s_tdata[1];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_delay_reg  <= '0;
            off_delay_reg <= '0;
            tps_reg       <= TPS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ON_FINAL_DELAY:  on_delay_reg  <= cfg_wdata[DelayWidth-1:0];
                REG_OFF_FINAL_DELAY: off_delay_reg <= cfg_wdata[DelayWidth-1:0];
                REG_TICKS_PER_SEC:   tps_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pick the wait length in seconds that the current step loads
    always_comb begin
        case (phase_reg)
            PH_STEP1: secs_sel = target_reg ? DelayWidth'(1) : '0;
            PH_STEP2: secs_sel = target_reg ? '0 : DelayWidth'(1);
            PH_STEP3: secs_sel = target_reg ? on_delay_reg : off_delay_reg;
            default:  secs_sel = '0;
        endcase
    end

    // Convert seconds to ticks; 8 x 16 bits fits the 24-bit counter exactly
    assign load_ticks = secs_sel * tps_reg;

    // Advance the sequence by one item
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        target_next = target_reg;
        status_next = status_reg;
        en_next     = en_reg;
        res_next    = '0;

        if (req_type) begin
            // Take a request only while idle
            if (phase_reg == PH_IDLE) begin
                target_next               = on_off;
                phase_next                = PH_STEP1;
                res_next.request_accepted = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_STEP1: begin
                    if (target_reg) begin
                        en_next[EN_MOTION] = 1'b1;
                        en_next[EN_AC]     = 1'b1;
                        en_next[EN_MAIN]   = 1'b1;
                    end else begin
                        en_next[EN_I2C]    = 1'b0;
                        en_next[EN_MOTION] = 1'b0;
                        en_next[EN_AC]     = 1'b0;
                        en_next[EN_VPP]    = 1'b0;
                    end
                    count_next = load_ticks;
                    phase_next = PH_WAIT1;
                end
                PH_WAIT1: begin
                    if (count_reg == '0) phase_next = PH_STEP2;
                    else                 count_next = count_reg - 1'b1;
                end
                PH_STEP2: begin
                    en_next[EN_HEATER] = target_reg;
                    count_next         = load_ticks;
                    phase_next         = PH_WAIT2;
                end
                PH_WAIT2: begin
                    if (count_reg == '0) phase_next = PH_STEP3;
                    else                 count_next = count_reg - 1'b1;
                end
                PH_STEP3: begin
                    if (target_reg) begin
                        en_next[EN_VPP] = 1'b1;
                        en_next[EN_I2C] = 1'b1;
                    end else begin
                        en_next[EN_MAIN] = 1'b0;
                    end
                    count_next = load_ticks;
                    phase_next = PH_FINAL;
                end
                PH_FINAL: begin
                    if (count_reg == '0) begin
                        status_next = target_reg;
                        phase_next  = PH_NOTIFY;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
                PH_NOTIFY: begin
                    // Offer the notification until the link takes it
                    res_next.notify_send  = 1'b1;
                    res_next.notify_level = status_reg;
                    if (notify_ready) phase_next = PH_IDLE;
                end
                default: ;
            endcase
        end

        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.enables      = en_next;
        res_next.power_status = status_next;
    end

    // Update state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            target_reg <= 1'b0;
            status_reg <= 1'b0;
            en_reg     <= '0;
        end else if (s_accept) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            target_reg <= target_next;
            status_reg <= status_next;
            en_reg     <= en_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, res_reg};

endmodule

`default_nettype wire
